// File: design/msr_pkg.sv
// Package for the missing segment tracker.
// Holds field widths, bitmap word geometry, action codes and the FSM state type.
// No dependencies.
package msr_pkg;

    localparam int SEG_W     = 12;
    localparam int CNT_W     = 13;
    localparam int WORD_W    = 32;
    localparam int BIT_IDX_W = 5;
    localparam int WIDX_W    = SEG_W - BIT_IDX_W;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    localparam logic ACT_ARRIVE = 1'b0;
    localparam logic ACT_POLL   = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ARRIVE,
        ST_POLL
    } state_t;

endpackage

// File: design/msr_ram.sv
// Generic simple dual-port RAM, one write port and one registered read port.
// Read data holds while no read is issued. No dependencies.
module msr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: design/missing_segment_tracker_core.sv
// Missing segment tracker: received-segment bitmap in RAM, scan pointer, arrival count.
// Depends on msr_pkg and msr_ram.
// Arrival: RAM read on acceptance, then modify, write back and result once m_ is free.
// Poll: scans 32-bit bitmap words from the pointer word onward, one RAM read per cycle,
// until a missing segment, the limit word or a pointer past the limit ends the scan.
// One item at a time; a new item is taken while the previous result waits at m_.
// Reset: a clearing pass writes zero to every bitmap word, one per cycle,
// ceil(min(MAX_SEGMENTS,4096)/32) words (128 by default); s_tready stays low meanwhile.
module missing_segment_tracker_core
    import msr_pkg::*;
#(
    parameter int MAX_SEGMENTS = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [11:0] cfg_wr_data,   // last_segment
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,       // [11:0] segment_number, [15:12] zero
    input  logic        s_tuser,       // [0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata        // [0] is_new, [1] missing_found,
                                       // [13:2] missing_segment, [14] all_received
);

    localparam int DEPTH  = (MAX_SEGMENTS < (1 << SEG_W)) ? MAX_SEGMENTS : (1 << SEG_W);
    localparam int NWORDS = (DEPTH + WORD_W - 1) / WORD_W;
    localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam logic [SEG_W-1:0] CAP       = SEG_W'(DEPTH - 1);
    localparam logic [AW-1:0]    LAST_WORD = AW'(NWORDS - 1);

    state_t              state_reg, state_next;
    logic [SEG_W-1:0]    last_seg_reg;
    logic [SEG_W-1:0]    ptr_reg, ptr_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [AW-1:0]       clr_addr_reg, clr_addr_next;
    logic [SEG_W-1:0]    seg_reg, seg_next;
    logic [WIDX_W-1:0]   cur_word_reg, cur_word_next;
    logic [BIT_IDX_W-1:0] start_bit_reg, start_bit_next;
    logic                beyond_reg, beyond_next;

    logic                out_valid_reg, out_valid_next;
    logic                out_new_reg, out_new_next;
    logic                out_found_reg, out_found_next;
    logic [SEG_W-1:0]    out_seg_reg, out_seg_next;
    logic                out_all_reg, out_all_next;

    logic                ram_wr_en, ram_rd_en;
    logic [AW-1:0]       ram_wr_addr, ram_rd_addr;
    logic [WORD_W-1:0]   ram_wr_data, ram_rd_data;

    logic [SEG_W-1:0]    lim;
    logic [WIDX_W-1:0]   lim_word;
    logic                out_free;
    logic [WORD_W-1:0]   mask_lo, mask_hi, cand;
    logic [BIT_IDX_W-1:0] hit_idx;
    logic [SEG_W-1:0]    hit_seg;
    logic                hit, arr_new;
    logic [CNT_W-1:0]    total;

    function automatic logic [BIT_IDX_W-1:0] first_set(input logic [WORD_W-1:0] v);
        logic [BIT_IDX_W-1:0] idx;
        idx = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (v[i]) idx = BIT_IDX_W'(i);
        end
        return idx;
    endfunction

    msr_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NWORDS)
    ) u_map (
        .clk     (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign lim      = (last_seg_reg > CAP) ? CAP : last_seg_reg;
    assign lim_word = lim[SEG_W-1:BIT_IDX_W];
    assign out_free = !out_valid_reg || m_tready;
    assign total    = CNT_W'(last_seg_reg) + CNT_W'(1);

    assign mask_lo  = {WORD_W{1'b1}} << start_bit_reg;
    assign mask_hi  = (cur_word_reg == lim_word)
                    ? ({WORD_W{1'b1}} >> (~lim[BIT_IDX_W-1:0])) : {WORD_W{1'b1}};
    assign cand     = ~ram_rd_data & mask_lo & mask_hi;
    assign hit      = |cand;
    assign hit_idx  = first_set(cand);
    assign hit_seg  = {cur_word_reg, hit_idx};
    assign arr_new  = (seg_reg <= lim) && !ram_rd_data[seg_reg[BIT_IDX_W-1:0]];

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_all_reg, out_seg_reg, out_found_reg, out_new_reg};

    always_comb begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        count_next     = count_reg;
        clr_addr_next  = clr_addr_reg;
        seg_next       = seg_reg;
        cur_word_next  = cur_word_reg;
        start_bit_next = start_bit_reg;
        beyond_next    = beyond_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_new_next   = out_new_reg;
        out_found_next = out_found_reg;
        out_seg_next   = out_seg_reg;
        out_all_next   = out_all_reg;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = '0;
        ram_wr_data    = '0;
        ram_rd_en      = 1'b0;
        ram_rd_addr    = '0;

        unique case (state_reg)
            ST_CLEAR: begin
                ram_wr_en     = 1'b1;
                ram_wr_addr   = clr_addr_reg;
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == LAST_WORD) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    ram_rd_en = 1'b1;
                    if (s_tuser == ACT_POLL) begin
                        ram_rd_addr    = AW'(ptr_reg[SEG_W-1:BIT_IDX_W]);
                        cur_word_next  = ptr_reg[SEG_W-1:BIT_IDX_W];
                        start_bit_next = ptr_reg[BIT_IDX_W-1:0];
                        beyond_next    = ptr_reg > lim;
                        state_next     = ST_POLL;
                    end else begin
                        ram_rd_addr = AW'(s_tdata[SEG_W-1:BIT_IDX_W]);
                        seg_next    = s_tdata[SEG_W-1:0];
                        state_next  = ST_ARRIVE;
                    end
                end
            end
            ST_ARRIVE: begin
                if (out_free) begin
                    if (arr_new) begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = AW'(seg_reg[SEG_W-1:BIT_IDX_W]);
                        ram_wr_data = ram_rd_data
                                    | (WORD_W'(1) << seg_reg[BIT_IDX_W-1:0]);
                        if (count_reg != COUNT_MAX) begin
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    out_valid_next = 1'b1;
                    out_new_next   = arr_new;
                    out_found_next = 1'b0;
                    out_seg_next   = '0;
                    out_all_next   = ((arr_new && count_reg != COUNT_MAX)
                                      ? count_reg + CNT_W'(1) : count_reg) == total;
                    state_next     = ST_IDLE;
                end
            end
            ST_POLL: begin
                if (beyond_reg || hit || cur_word_reg == lim_word) begin
                    if (out_free) begin
                        out_valid_next = 1'b1;
                        out_new_next   = 1'b0;
                        out_found_next = !beyond_reg && hit;
                        out_seg_next   = (!beyond_reg && hit) ? hit_seg : '0;
                        out_all_next   = count_reg == total;
                        ptr_next       = (!beyond_reg && hit && hit_seg != lim)
                                       ? hit_seg + SEG_W'(1) : '0;
                        state_next     = ST_IDLE;
                    end
                end else begin
                    ram_rd_en      = 1'b1;
                    ram_rd_addr    = cur_word_reg[AW-1:0] + AW'(1);
                    cur_word_next  = cur_word_reg + WIDX_W'(1);
                    start_bit_next = '0;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            last_seg_reg  <= '0;
            ptr_reg       <= '0;
            count_reg     <= '0;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            count_reg     <= count_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en) begin
                last_seg_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        seg_reg       <= seg_next;
        cur_word_reg  <= cur_word_next;
        start_bit_reg <= start_bit_next;
        beyond_reg    <= beyond_next;
        out_new_reg   <= out_new_next;
        out_found_reg <= out_found_next;
        out_seg_reg   <= out_seg_next;
        out_all_reg   <= out_all_next;
    end

    a_no_result_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !out_valid_reg)
        else $error("result produced during clearing pass");

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("arrival count exceeds bitmap size");

    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ram_wr_en && ram_rd_en))
        else $error("bitmap read and write in the same cycle");

    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_POLL && !beyond_reg) |-> cur_word_reg <= lim_word)
        else $error("scan ran past the last segment word");

    a_accept_starts_work: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_ARRIVE || state_reg == ST_POLL))
        else $error("accepted transfer not processed");

endmodule

// File: verif/tb.sv
// Self-checking testbench for missing_segment_tracker_core.
// Drives stream arrivals and polls under random pacing and back-pressure and checks each
// result against a built-in predictor or directed values. Depends on msr_pkg, core RTL.
`timescale 1ns / 100ps

module tb
    import msr_pkg::*;
();

    localparam int SEG_CAP = 4095;

    typedef struct packed {
        logic             is_new;
        logic             found;
        logic [SEG_W-1:0] missing;
        logic             all_rcvd;
    } seg_status_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t        kind;
        logic             act;
        logic [SEG_W-1:0] val;
        logic             typed;
        seg_status_t      want;
    } stim_row_t;

    logic             aclk;
    logic             aresetn     = 1'b0;
    logic             cfg_wr_en   = 1'b0;
    logic [11:0]      cfg_wr_data = '0;
    logic             s_tvalid    = 1'b0;
    logic             s_tready;
    logic [15:0]      s_tdata     = '0;
    logic             s_tuser     = 1'b0;
    logic             m_tvalid;
    logic             m_tready    = 1'b0;
    logic [15:0]      m_tdata;

    // tracker shadow state
    bit               seen_map [0:4095];
    logic [SEG_W-1:0] scan_ptr   = '0;
    logic [CNT_W-1:0] arrive_cnt = '0;
    logic [SEG_W-1:0] seg_limit  = '0;

    seg_status_t      due_reports [$];
    stim_row_t        rows [$];
    seg_status_t      got_r, want_r;
    int               err_cnt    = 0;
    int               burst_left = 0;
    int               rx_left    = 0;
    int               rx_mode    = 0;
    logic [7:0]       rx_mask    = 8'b1011_0010;

    missing_segment_tracker_core uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("missing_segment_tracker_core regression: fail");
        $finish;
    end

    function automatic seg_status_t status(input logic n, input logic f,
                                           input logic [SEG_W-1:0] s, input logic a);
        seg_status_t r;
        r.is_new   = n;
        r.found    = f;
        r.missing  = s;
        r.all_rcvd = a;
        return r;
    endfunction

    function automatic seg_status_t track_step(input logic act, input logic [SEG_W-1:0] seg);
        seg_status_t r;
        int          lim;
        int          i;
        r   = '0;
        lim = (int'(seg_limit) < SEG_CAP) ? int'(seg_limit) : SEG_CAP;
        if (act == ACT_ARRIVE) begin
            if (int'(seg) <= lim && !seen_map[seg]) begin
                seen_map[seg] = 1'b1;
                r.is_new      = 1'b1;
                if (arrive_cnt != COUNT_MAX)
                    arrive_cnt = arrive_cnt + 1'b1;
            end
        end else begin
            for (i = int'(scan_ptr); i <= lim && !r.found; i++) begin
                if (!seen_map[i]) begin
                    r.found   = 1'b1;
                    r.missing = SEG_W'(i);
                end
            end
            scan_ptr = (!r.found || int'(r.missing) == lim) ? '0 : r.missing + 1'b1;
        end
        r.all_rcvd = (arrive_cnt == {1'b0, seg_limit} + 1'b1);
        return r;
    endfunction

    // first segment not yet seen, scanning from start with wrap
    function automatic logic [SEG_W-1:0] pick_missing(input int start);
        int k;
        int idx;
        for (k = 0; k <= int'(seg_limit); k++) begin
            idx = (start + k) % (int'(seg_limit) + 1);
            if (!seen_map[idx])
                return SEG_W'(idx);
        end
        return SEG_W'(start);
    endfunction

    task automatic add_row(input row_kind_t k, input logic a, input logic [SEG_W-1:0] v,
                           input logic t, input seg_status_t w);
        stim_row_t r;
        r.kind  = k;
        r.act   = a;
        r.val   = v;
        r.typed = t;
        r.want  = w;
        rows.push_back(r);
    endtask

    task automatic drive_item(input logic act, input logic [SEG_W-1:0] seg,
                              input logic typed, input seg_status_t want);
        seg_status_t pred;
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, seg};
        s_tuser  <= act;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        pred = track_step(act, seg);
        due_reports.push_back(typed ? want : pred);
    endtask

    task automatic pace;
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap        = $urandom_range(1, 15);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(0, 30);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic drain_results;
        s_tvalid <= 1'b0;
        while (due_reports.size() != 0)
            @(posedge aclk);
    endtask

    task automatic set_limit(input logic [SEG_W-1:0] v);
        drain_results();
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        seg_limit    = v;
    endtask

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_r = status(m_tdata[0], m_tdata[1], m_tdata[13:2], m_tdata[14]);
            if (due_reports.size() == 0) begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display("ERROR: unexpected transfer, m_tdata=%h", m_tdata);
            end else begin
                want_r = due_reports.pop_front();
                if (got_r.is_new !== want_r.is_new || got_r.found !== want_r.found ||
                    got_r.missing !== want_r.missing ||
                    got_r.all_rcvd !== want_r.all_rcvd) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display({"ERROR: exp new=%0b found=%0b seg=%0d all=%0b, ",
                                  "got new=%0b found=%0b seg=%0d all=%0b"},
                                 want_r.is_new, want_r.found, want_r.missing,
                                 want_r.all_rcvd, got_r.is_new, got_r.found,
                                 got_r.missing, got_r.all_rcvd);
                end
            end
        end
    end

    // receiver back-pressure
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(8, 200);
        end else begin
            rx_left--;
        end
        rx_mask = {rx_mask[6:0], rx_mask[7]};
        case (rx_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= rx_mask[0];
            default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    initial begin
        int phase_lim [12] = '{5, 7, 31, 33, 64, 4095, 40, 127, 255, 0, -1, 200};
        int phase_len [12] = '{60, 80, 150, 60, 150, 80, 100, 250, 250, 40, 80, 100};
        int p;
        int n;
        int sel;
        logic             act;
        logic [SEG_W-1:0] seg;

        // directed: last_segment starts at 0 after reset
        add_row(ROW_ITEM, ACT_POLL,   12'd0,    1'b1, status(0, 1, 0, 0));
        add_row(ROW_ITEM, ACT_ARRIVE, 12'd4095, 1'b1, status(0, 0, 0, 0));
        add_row(ROW_ITEM, ACT_ARRIVE, 12'd0,    1'b1, status(1, 0, 0, 1));
        add_row(ROW_ITEM, ACT_ARRIVE, 12'd0,    1'b1, status(0, 0, 0, 1));
        add_row(ROW_ITEM, ACT_POLL,   12'd4095, 1'b1, status(0, 0, 0, 1));
        add_row(ROW_CFG,  ACT_ARRIVE, 12'd4095, 1'b0, '0);
        add_row(ROW_ITEM, ACT_ARRIVE, 12'd4095, 1'b1, status(1, 0, 0, 0));
        add_row(ROW_ITEM, ACT_POLL,   12'd0,    1'b1, status(0, 1, 1, 0));
        add_row(ROW_ITEM, ACT_POLL,   12'd0,    1'b1, status(0, 1, 2, 0));
        add_row(ROW_ITEM, ACT_ARRIVE, 12'd2048, 1'b0, '0);
        add_row(ROW_ITEM, ACT_ARRIVE, 12'hAAA,  1'b0, '0);
        add_row(ROW_ITEM, ACT_ARRIVE, 12'h555,  1'b0, '0);
        add_row(ROW_ITEM, ACT_POLL,   12'hFFF,  1'b0, '0);
        // lowered limit leaves the scan pointer past it
        add_row(ROW_CFG,  ACT_ARRIVE, 12'd1,    1'b0, '0);
        add_row(ROW_ITEM, ACT_POLL,   12'd0,    1'b1, status(0, 0, 0, 0));
        add_row(ROW_ITEM, ACT_POLL,   12'd0,    1'b1, status(0, 1, 1, 0));
        add_row(ROW_ITEM, ACT_ARRIVE, 12'd1,    1'b1, status(1, 0, 0, 0));
        add_row(ROW_ITEM, ACT_ARRIVE, 12'd2,    1'b1, status(0, 0, 0, 0));
        add_row(ROW_CFG,  ACT_ARRIVE, 12'd5,    1'b0, '0);
        add_row(ROW_ITEM, ACT_POLL,   12'd0,    1'b1, status(0, 1, 2, 1));
        add_row(ROW_ITEM, ACT_POLL,   12'd0,    1'b1, status(0, 1, 3, 1));
        add_row(ROW_ITEM, ACT_ARRIVE, 12'd5,    1'b1, status(1, 0, 0, 0));

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (rows[i]) begin
            if (rows[i].kind == ROW_CFG) begin
                set_limit(rows[i].val);
            end else begin
                drive_item(rows[i].act, rows[i].val, rows[i].typed, rows[i].want);
                pace();
            end
        end

        for (p = 0; p < 12; p++) begin
            set_limit(SEG_W'(phase_lim[p] < 0 ? $urandom_range(0, 4095) : phase_lim[p]));
            for (n = 0; n < phase_len[p]; n++) begin
                sel = $urandom_range(0, 99);
                act = (sel < 35) ? ACT_POLL : ACT_ARRIVE;
                if (sel < 35)
                    seg = SEG_W'($urandom_range(0, 4095));
                else if (sel < 65)
                    seg = pick_missing($urandom_range(0, seg_limit));
                else if (sel < 88)
                    seg = SEG_W'($urandom_range(0, seg_limit));
                else
                    seg = SEG_W'($urandom_range(0, 4095));
                drive_item(act, seg, 1'b0, '0);
                if ($urandom_range(0, 99) == 0)
                    drain_results();
                else
                    pace();
            end
        end

        drain_results();
        repeat (300) @(posedge aclk);
        if (err_cnt == 0)
            $display("missing_segment_tracker_core regression: pass");
        else
            $display("missing_segment_tracker_core regression: fail");
        $finish;
    end

endmodule
